// ----- design/sida_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sida_pkg: shared types and constants
// Character codes, digit correction constants and the command bundle that the
// sequencer sends to the conversion unit.
// ----------------------------------------------------------------------------
package sida_pkg;

  localparam logic [6:0] ASCII_ZERO  = 7'd48;
  localparam logic [6:0] ASCII_MINUS = 7'd45;
  localparam logic [3:0] BCD_LIMIT   = 4'd5;
  localparam logic [3:0] BCD_ADJUST  = 4'd3;

  typedef struct packed {
    logic load;
    logic step;
    logic shift_out;
  } bcd_cmd_t;

endpackage
`default_nettype wire

// ----- design/sida_bcd.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sida_bcd: shift-and-add-3 conversion unit
// Holds the magnitude and the decimal digit row; one correction and shift step
// per cycle, each digit with its own corrector, then shifts the digits out, most significant first.
// ----------------------------------------------------------------------------
module sida_bcd #(
  parameter int VALUE_BITS = 32,
  parameter int DIGITS     = 10
) (
  input  wire logic                    clk,
  input  wire sida_pkg::bcd_cmd_t      cmd,
  input  wire logic [VALUE_BITS-1:0]   mag_in,
  output logic [3:0]                   top_digit
);
  import sida_pkg::*;

  localparam int BCD_W = DIGITS * 4;

  logic [VALUE_BITS-1:0] mag_r;
  logic [VALUE_BITS-1:0] mag_nxt;
  logic [BCD_W-1:0]      bcd_r;
  logic [BCD_W-1:0]      bcd_nxt;
  logic [BCD_W-1:0]      adj;

  for (genvar g = 0; g < DIGITS; g++) begin : g_adj
    assign adj[4*g +: 4] = (bcd_r[4*g +: 4] >= BCD_LIMIT) ?
                           bcd_r[4*g +: 4] + BCD_ADJUST : bcd_r[4*g +: 4];
  end

  always_comb begin
    mag_nxt = mag_r;
    bcd_nxt = bcd_r;
    if (cmd.load) begin
      mag_nxt = mag_in;
      bcd_nxt = '0;
    end else if (cmd.step) begin
      bcd_nxt = {adj[BCD_W-2:0], mag_r[VALUE_BITS-1]};
      mag_nxt = {mag_r[VALUE_BITS-2:0], 1'b0};
    end else if (cmd.shift_out) begin
      bcd_nxt = {bcd_r[BCD_W-5:0], 4'd0};
    end
  end

  always_ff @(posedge clk) begin
    mag_r <= mag_nxt;
    bcd_r <= bcd_nxt;
  end

  assign top_digit = bcd_r[BCD_W-1 -: 4];

endmodule
`default_nettype wire

// ----- design/sida_seq.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sida_seq: conversion sequencer and character output register
// Steps the conversion unit once per magnitude bit, then scans the digit row,
// drops leading zeros and issues one character per output transaction.
// ----------------------------------------------------------------------------
module sida_seq #(
  parameter int VALUE_BITS = 32,
  parameter int DIGITS     = 10
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_valid,
  input  wire logic                 in_negative,
  output logic                      in_stall,
  input  wire logic [3:0]           top_digit,
  output sida_pkg::bcd_cmd_t        cmd,
  output logic                      out_valid,
  input  wire logic                 out_stall,
  output logic [6:0]                out_char_code,
  output logic                      out_last
);
  import sida_pkg::*;

  localparam int CNT_W = $clog2(VALUE_BITS + 1);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CONV,
    ST_SIGN,
    ST_EMIT
  } state_t;

  state_t           state_r, state_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             neg_r, neg_nxt;
  logic             started_r, started_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic [6:0]       out_char_r, out_char_nxt;
  logic             out_last_r, out_last_nxt;
  logic             slot_free;
  logic             cnt_one;

  assign slot_free = !out_valid_r || !out_stall;
  assign cnt_one   = (cnt_r == CNT_W'(1));

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    neg_nxt       = neg_r;
    started_nxt   = started_r;
    out_valid_nxt = out_valid_r;
    out_char_nxt  = out_char_r;
    out_last_nxt  = out_last_r;
    cmd           = '0;
    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          neg_nxt   = in_negative;
          cnt_nxt   = CNT_W'(VALUE_BITS);
          state_nxt = ST_CONV;
        end
      end
      ST_CONV: begin
        cmd.step = 1'b1;
        cnt_nxt  = cnt_r - CNT_W'(1);
        if (cnt_one) begin
          cnt_nxt     = CNT_W'(DIGITS);
          started_nxt = 1'b0;
          state_nxt   = neg_r ? ST_SIGN : ST_EMIT;
        end
      end
      ST_SIGN: begin
        if (slot_free) begin
          out_valid_nxt = 1'b1;
          out_char_nxt  = ASCII_MINUS;
          out_last_nxt  = 1'b0;
          state_nxt     = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (top_digit == 4'd0 && !started_r && !cnt_one) begin
          cmd.shift_out = 1'b1;
          cnt_nxt       = cnt_r - CNT_W'(1);
        end else if (slot_free) begin
          cmd.shift_out = 1'b1;
          cnt_nxt       = cnt_r - CNT_W'(1);
          started_nxt   = 1'b1;
          out_valid_nxt = 1'b1;
          out_char_nxt  = ASCII_ZERO + {3'd0, top_digit};
          out_last_nxt  = cnt_one;
          if (cnt_one) begin
            state_nxt = ST_IDLE;
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      neg_r       <= 1'b0;
      started_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      neg_r       <= neg_nxt;
      started_r   <= started_nxt;
      out_valid_r <= out_valid_nxt;
    end
    out_char_r <= out_char_nxt;
    out_last_r <= out_last_nxt;
  end

  assign in_stall      = (state_r != ST_IDLE);
  assign out_valid     = out_valid_r;
  assign out_char_code = out_char_r;
  assign out_last      = out_last_r;

endmodule
`default_nettype wire

// ----- design/signed_int_to_decimal_ascii.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// signed_int_to_decimal_ascii: signed integer to decimal ASCII text
// Converts a two's complement value to its decimal text, sign first, one
// character per output transaction, last character marked.
// ----------------------------------------------------------------------------
//  channel | ports                               | direction
//  --------+-------------------------------------+----------
//  in      | in_valid, in_stall, in_value        | in
//  out     | out_valid, out_stall, out_char_code,| out
//          | out_last                            |
//
//  Steps: accept, VALUE_BITS shift-and-add-3 steps, a minus sign if negative,
//  then a scan over the DIGITS digits of the digit row.
//  The shift-and-add-3 step, applied to every digit of the row at once, sets the conversion time.
//  in_stall is high from acceptance until the final character is registered.
//  A stalled output holds its character; scanning of leading zeros continues.
//  Reset is synchronous and active low; it clears the sequencer and out_valid.
// ----------------------------------------------------------------------------
module signed_int_to_decimal_ascii #(
  parameter int VALUE_BITS = 32
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_valid,
  output logic                       in_stall,
  input  wire logic [VALUE_BITS-1:0] in_value,
  output logic                       out_valid,
  input  wire logic                  out_stall,
  output logic [6:0]                 out_char_code,
  output logic                       out_last
);
  import sida_pkg::*;

  localparam int DIGITS = ((VALUE_BITS - 1) * 30103) / 100000 + 1;

  logic                  negative;
  logic [VALUE_BITS-1:0] magnitude;
  logic [3:0]            top_digit;
  bcd_cmd_t              cmd;

  assign negative  = in_value[VALUE_BITS-1];
  assign magnitude = negative ? (~in_value + VALUE_BITS'(1)) : in_value;

  sida_bcd #(
    .VALUE_BITS (VALUE_BITS),
    .DIGITS     (DIGITS)
  ) u_bcd (
    .clk       (clk),
    .cmd       (cmd),
    .mag_in    (magnitude),
    .top_digit (top_digit)
  );

  sida_seq #(
    .VALUE_BITS (VALUE_BITS),
    .DIGITS     (DIGITS)
  ) u_seq (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_negative   (negative),
    .in_stall      (in_stall),
    .top_digit     (top_digit),
    .cmd           (cmd),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_char_code (out_char_code),
    .out_last      (out_last)
  );

endmodule
`default_nettype wire

// ----- tb/testbench.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: signed integer to decimal ASCII converter
// Feeds signed 32-bit values, both extremes, zero, powers of ten and random
// values, while sender and receiver idle at random in two phases. Every value
// accepted is turned into its expected character string, and each character
// transaction is checked in order against it, code and last flag alike.
// ----------------------------------------------------------------------------
module testbench;

  localparam int VALUE_BITS     = 32;
  localparam int DECIMAL_BASE   = 10;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int RANDOM_PER_PHASE = 34;

  typedef struct packed {
    logic [6:0] char_code;
    logic       last;
  } decimal_char_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_valid = 1'b0;
  logic                  in_stall;
  logic [VALUE_BITS-1:0] in_value = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  logic [6:0]            out_char_code;
  logic                  out_last;

  logic [VALUE_BITS-1:0] stim_values[$];
  decimal_char_t         expected_text[$];
  int                    error_count = 0;
  int                    quiet_cycles = 0;
  int                    sender_idle_pct = 0;
  int                    receiver_idle_pct = 0;

  signed_int_to_decimal_ascii #(
    .VALUE_BITS(VALUE_BITS)
  ) i_dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_value     (in_value),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_char_code(out_char_code),
    .out_last     (out_last)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  task automatic report_mismatch(input string what);
    $display("[%0t] ERROR: %s", $realtime, what);
    error_count++;
  endtask

  function automatic void predict_decimal_text(input logic [VALUE_BITS-1:0] value);
    logic [VALUE_BITS-1:0] mag;
    logic [3:0]            digits[20];
    int                    count;
    int                    i;
    decimal_char_t         c;
    mag = value[VALUE_BITS-1] ? ('0 - value) : value;
    count = 0;
    if (mag == '0) begin
      digits[0] = 4'd0;
      count = 1;
    end
    while (mag != '0) begin
      digits[count] = 4'(mag % DECIMAL_BASE);
      mag = mag / DECIMAL_BASE;
      count++;
    end
    if (value[VALUE_BITS-1]) begin
      c.char_code = sida_pkg::ASCII_MINUS;
      c.last = 1'b0;
      expected_text.push_back(c);
    end
    for (i = count - 1; i >= 0; i--) begin
      c.char_code = sida_pkg::ASCII_ZERO + 7'(digits[i]);
      c.last = (i == 0);
      expected_text.push_back(c);
    end
  endfunction

  function automatic logic [VALUE_BITS-1:0] next_test_value();
    logic [VALUE_BITS-1:0] v;
    logic [VALUE_BITS-1:0] p;
    int                    k;
    case ($urandom_range(4))
      0, 1: v = $urandom;
      2: v = $urandom_range(999);
      3: begin
        p = 1;
        k = $urandom_range(9);
        repeat (k) p = p * DECIMAL_BASE;
        v = p + $urandom_range(2) - 1;
      end
      default: v = $urandom_range(1) ? {1'b1, {(VALUE_BITS-1){1'b0}}} :
                                       {1'b0, {(VALUE_BITS-1){1'b1}}};
    endcase
    if ($urandom_range(1)) begin
      v = '0 - v;
    end
    return v;
  endfunction

  task automatic wait_for_drain();
    while (stim_values.size() != 0 || in_valid || expected_text.size() != 0) begin
      @(negedge clk);
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        predict_decimal_text(in_value);
      end
      if (!in_valid || !in_stall) begin
        if (stim_values.size() != 0 && $urandom_range(99) >= sender_idle_pct) begin
          in_valid <= 1'b1;
          in_value <= stim_values.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < receiver_idle_pct);
  end

  always @(posedge clk) begin
    decimal_char_t e;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_text.size() == 0) begin
        report_mismatch($sformatf("unexpected character %0d last %0b",
                                  out_char_code, out_last));
      end else begin
        e = expected_text.pop_front();
        if (out_char_code !== e.char_code) begin
          report_mismatch($sformatf("char_code %0d, expected %0d",
                                    out_char_code, e.char_code));
        end
        if (out_last !== e.last) begin
          report_mismatch($sformatf("last %0b, expected %0b on char %0d",
                                    out_last, e.last, e.char_code));
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    sender_idle_pct = 35;
    receiver_idle_pct = 48;
    stim_values.push_back(32'sd0);
    stim_values.push_back(32'sd1);
    stim_values.push_back(-32'sd1);
    stim_values.push_back(32'sd9);
    stim_values.push_back(32'sd10);
    stim_values.push_back(-32'sd10);
    stim_values.push_back(32'sd99);
    stim_values.push_back(32'sd100);
    stim_values.push_back(32'h7FFF_FFFF);
    stim_values.push_back(32'h8000_0000);
    stim_values.push_back(32'h8000_0001);
    stim_values.push_back(32'sd1000000000);
    stim_values.push_back(32'sd999999999);
    stim_values.push_back(-32'sd999999999);
    stim_values.push_back(-32'sd1000000000);
    stim_values.push_back(32'hAAAA_AAAA);
    stim_values.push_back(32'h5555_5555);
    stim_values.push_back(32'sd12345);
    stim_values.push_back(-32'sd7);
    repeat (RANDOM_PER_PHASE) stim_values.push_back(next_test_value());
    wait_for_drain();

    sender_idle_pct = 48;
    receiver_idle_pct = 35;
    repeat (RANDOM_PER_PHASE) stim_values.push_back(next_test_value());
    wait_for_drain();

    sender_idle_pct = 0;
    receiver_idle_pct = 0;
    repeat (RANDOM_PER_PHASE) stim_values.push_back(next_test_value());
    wait_for_drain();

    repeat (60) @(posedge clk);
    if (error_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

// ----- files.f -----
design/sida_pkg.sv
design/sida_bcd.sv
design/sida_seq.sv
design/signed_int_to_decimal_ascii.sv
tb/testbench.sv
